### src/relative_absolute_time_converter_macros.svh
// Assertion macros shared by the time converter RTL.
// Expect i_clk and synchronous active-low i_rst_n in the using module.
`ifndef RELATIVE_ABSOLUTE_TIME_CONVERTER_MACROS_SVH
`define RELATIVE_ABSOLUTE_TIME_CONVERTER_MACROS_SVH

// same-cycle implication
`define RAT_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RAT_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rat_pkg.sv
// Package for the relative/absolute time converter.
// Types, opcodes and constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rat_pkg;

    localparam int CHANNELS = 8;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NSTG     = 9;
    localparam int LAST     = NSTG - 1;

    localparam logic [23:0] TICKS     = 24'd10000000;
    localparam logic [24:0] TWO_TICKS = 25'd20000000;
    // floor(2^41 / 78125); quotient estimate is exact or one low
    localparam logic [24:0] RECIP     = 25'd28147497;

    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_R2A = 2'd1,
        OP_A2R = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef struct packed {
        logic [47:0] counter;
        logic [31:0] seconds;
        logic [23:0] fraction;
        logic        format;
    } t_ref;

    typedef struct packed {
        t_op         op;
        logic [2:0]  channel;
        logic [47:0] rel_time;
        logic [31:0] abs_seconds;
        logic [23:0] abs_fraction;
        logic        date_format;
    } t_item;

    typedef struct packed {
        t_op  op;
        logic fmt;
    } t_ctx;

    // per-stage load enable and valid
    typedef struct packed {
        logic [NSTG-1:0] en;
        logic [NSTG-1:0] v;
    } t_pipe;

endpackage

`default_nettype wire

### src/rat_ref_table.sv
// Per-channel time reference registers, cleared by reset.
// Depends on rat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rat_ref_table (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_we,
    input  wire logic [rat_pkg::IDX_W-1:0] i_idx,
    input  wire rat_pkg::t_ref            i_wr_data,
    output rat_pkg::t_ref                 o_rd_data
);

    rat_pkg::t_ref r_tab [rat_pkg::CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rat_pkg::CHANNELS; i++) begin
                r_tab[i] <= '0;
            end
        end else if (i_we) begin
            r_tab[i_idx] <= i_wr_data;
        end
    end

    assign o_rd_data = r_tab[i_idx];

endmodule

`default_nettype wire

### src/rat_r2a.sv
// Relative-to-absolute datapath: signed counter difference split by 1e7
// through reciprocal multiply, then added to the reference. Uses rat_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "relative_absolute_time_converter_macros.svh"

module rat_r2a (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rat_pkg::t_pipe i_pipe,
    input  wire logic [47:0]    i_rel_time,
    input  wire rat_pkg::t_ref  i_ref,
    output logic [31:0]         o_seconds,
    output logic [23:0]         o_fraction
);

    logic        r_neg   [1:6];
    logic [31:0] r_rsec  [1:6];
    logic [23:0] r_rfrac [1:6];
    logic [47:0] r_n     [1:4];
    logic [56:0] r_plo;
    logic [33:0] r_phi;
    logic [24:0] r_q3;
    logic [24:0] r_q4;
    logic [47:0] r_qm4;
    logic [24:0] r_q5;
    logic [24:0] r_rem5;
    logic [24:0] r_q6;
    logic [23:0] r_r6;
    logic [31:0] r_sec7;
    logic [25:0] r_frac7;

    logic        n_neg;
    logic [47:0] n_mag;
    logic [56:0] n_plo;
    logic [33:0] n_phi;
    logic [65:0] n_qsum;
    logic [48:0] n_qm;
    logic [47:0] n_rem;
    logic        n_fix;
    logic [24:0] n_rfix;
    logic [31:0] n_sec7;
    logic [25:0] n_frac7;
    logic        f_neg;
    logic        f_ge2;
    logic        f_ge1;
    logic [25:0] f_frac;

    assign n_neg  = i_rel_time < i_ref.counter;
    assign n_mag  = n_neg ? (i_ref.counter - i_rel_time) : (i_rel_time - i_ref.counter);
    assign n_plo  = r_n[1][38:7] * rat_pkg::RECIP;
    assign n_phi  = r_n[1][47:39] * rat_pkg::RECIP;
    assign n_qsum = {9'b0, r_plo} + {r_phi, 32'b0};
    assign n_qm   = r_q3 * rat_pkg::TICKS;
    assign n_rem  = r_n[4] - r_qm4;
    assign n_fix  = r_rem5 >= {1'b0, rat_pkg::TICKS};
    assign n_rfix = r_rem5 - {1'b0, rat_pkg::TICKS};
    assign n_sec7 = r_neg[6] ? (r_rsec[6] - {7'b0, r_q6}) : (r_rsec[6] + {7'b0, r_q6});
    assign n_frac7 = r_neg[6] ? ({2'b0, r_rfrac[6]} - {2'b0, r_r6})
                              : ({2'b0, r_rfrac[6]} + {2'b0, r_r6});

    always_ff @(posedge i_clk) begin
        if (i_pipe.en[1]) begin
            r_neg[1]   <= n_neg;
            r_n[1]     <= n_mag;
            r_rsec[1]  <= i_ref.seconds;
            r_rfrac[1] <= i_ref.fraction;
        end
        for (int k = 2; k <= 6; k++) begin
            if (i_pipe.en[k]) begin
                r_neg[k]   <= r_neg[k-1];
                r_rsec[k]  <= r_rsec[k-1];
                r_rfrac[k] <= r_rfrac[k-1];
            end
        end
        for (int k = 2; k <= 4; k++) begin
            if (i_pipe.en[k]) begin
                r_n[k] <= r_n[k-1];
            end
        end
        if (i_pipe.en[2]) begin
            r_plo <= n_plo;
            r_phi <= n_phi;
        end
        if (i_pipe.en[3]) begin
            r_q3 <= n_qsum[65:41];
        end
        if (i_pipe.en[4]) begin
            r_q4  <= r_q3;
            r_qm4 <= n_qm[47:0];
        end
        if (i_pipe.en[5]) begin
            r_q5   <= r_q4;
            r_rem5 <= n_rem[24:0];
        end
        if (i_pipe.en[6]) begin
            r_q6 <= n_fix ? (r_q5 + 25'd1) : r_q5;
            r_r6 <= n_fix ? n_rfix[23:0] : r_rem5[23:0];
        end
        if (i_pipe.en[7]) begin
            r_sec7  <= n_sec7;
            r_frac7 <= n_frac7;
        end
    end

    // fraction lies in -1e7 .. 3e7-1: one borrow or up to two carries
    assign f_neg = r_frac7[25];
    assign f_ge2 = !f_neg && (r_frac7 >= {1'b0, rat_pkg::TWO_TICKS});
    assign f_ge1 = !f_neg && (r_frac7 >= {2'b0, rat_pkg::TICKS});

    always_comb begin
        if (f_neg) begin
            f_frac    = r_frac7 + {2'b0, rat_pkg::TICKS};
            o_seconds = r_sec7 - 32'd1;
        end else if (f_ge2) begin
            f_frac    = r_frac7 - {1'b0, rat_pkg::TWO_TICKS};
            o_seconds = r_sec7 + 32'd2;
        end else if (f_ge1) begin
            f_frac    = r_frac7 - {2'b0, rat_pkg::TICKS};
            o_seconds = r_sec7 + 32'd1;
        end else begin
            f_frac    = r_frac7;
            o_seconds = r_sec7;
        end
    end

    assign o_fraction = f_frac[23:0];

    `RAT_CHECK(a_rem_bound, i_pipe.v[5], r_rem5 < rat_pkg::TWO_TICKS, "remainder estimate off by more than one")
    `RAT_CHECK(a_rem_fixed, i_pipe.v[6], r_r6 < rat_pkg::TICKS, "corrected remainder out of range")
    `RAT_CHECK(a_frac_norm, i_pipe.v[7], o_fraction < rat_pkg::TICKS, "fraction not normalized")

endmodule

`default_nettype wire

### src/rat_a2r.sv
// Absolute-to-relative datapath: seconds difference times 1e7 plus
// fraction difference plus reference counter, modulo 2^48. Uses rat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rat_a2r (
    input  wire logic           i_clk,
    input  wire rat_pkg::t_pipe i_pipe,
    input  wire logic [31:0]    i_abs_seconds,
    input  wire logic [23:0]    i_abs_fraction,
    input  wire rat_pkg::t_ref  i_ref,
    output logic [47:0]         o_rel_time
);

    logic [32:0] r_sd1;
    logic [24:0] r_fd1;
    logic [47:0] r_rc  [1:3];
    logic [55:0] r_pp2;
    logic        r_sgn2;
    logic [24:0] r_fd2;
    logic [47:0] r_t3;
    logic [47:0] r_rel [4:7];

    logic [55:0] n_pp2;
    logic [47:0] n_corr;
    logic [47:0] n_t3;

    assign n_pp2  = r_sd1[31:0] * rat_pkg::TICKS;
    // negative seconds difference: subtract 1e7 * 2^32 modulo 2^48
    assign n_corr = r_sgn2 ? {rat_pkg::TICKS[15:0], 32'b0} : 48'b0;
    assign n_t3   = r_pp2[47:0] - n_corr + {{23{r_fd2[24]}}, r_fd2};

    always_ff @(posedge i_clk) begin
        if (i_pipe.en[1]) begin
            r_sd1  <= {1'b0, i_abs_seconds} - {1'b0, i_ref.seconds};
            r_fd1  <= {1'b0, i_abs_fraction} - {1'b0, i_ref.fraction};
            r_rc[1] <= i_ref.counter;
        end
        for (int k = 2; k <= 3; k++) begin
            if (i_pipe.en[k]) begin
                r_rc[k] <= r_rc[k-1];
            end
        end
        if (i_pipe.en[2]) begin
            r_pp2  <= n_pp2;
            r_sgn2 <= r_sd1[32];
            r_fd2  <= r_fd1;
        end
        if (i_pipe.en[3]) begin
            r_t3 <= n_t3;
        end
        if (i_pipe.en[4]) begin
            r_rel[4] <= r_t3 + r_rc[3];
        end
        for (int k = 5; k <= 7; k++) begin
            if (i_pipe.en[k]) begin
                r_rel[k] <= r_rel[k-1];
            end
        end
    end

    assign o_rel_time = r_rel[7];

endmodule

`default_nettype wire

### src/relative_absolute_time_converter.sv
// An accepted item is captured in r_in, then moves stage by stage until o_valid rises.
// Throughput: one item per cycle while o_stall stays low; set by the 9-stage pipeline (reference
// lookup, split multiplies for the divide by 1e7, correction, normalize).
// Stages move independently, so bubbles close up behind a stalled output.
// Reset (synchronous, active low) empties the pipeline and zeroes all
// channel references.
`timescale 1ns / 1ps
`default_nettype none
`include "relative_absolute_time_converter_macros.svh"

module relative_absolute_time_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [2:0]  i_channel,
    input  wire logic [47:0] i_rel_time,
    input  wire logic [31:0] i_abs_seconds,
    input  wire logic [23:0] i_abs_fraction,
    input  wire logic        i_date_format,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_out_seconds,
    output logic [23:0]      o_out_fraction,
    output logic             o_out_format,
    output logic [47:0]      o_out_rel_time
);

    localparam int LAST = rat_pkg::LAST;

    typedef struct packed {
        rat_pkg::t_op op;
        logic [31:0]  seconds;
        logic [23:0]  fraction;
        logic         format;
        logic [47:0]  rel_time;
    } t_out;

    logic [LAST:0]  r_v;
    logic [LAST:0]  rdy;
    rat_pkg::t_item r_in;
    rat_pkg::t_ctx  r_ctx [1:LAST-1];
    t_out           r_out;
    t_out           n_out;

    rat_pkg::t_op   n_op;
    logic           n_fmt;
    logic           ch_ok;
    logic           wr_en;
    rat_pkg::t_ref  wr_data;
    rat_pkg::t_ref  rd_data;
    rat_pkg::t_pipe pipe;
    logic [31:0]    r2a_sec;
    logic [23:0]    r2a_frac;
    logic [47:0]    a2r_rel;

    always_comb begin
        rdy[LAST] = !r_v[LAST] || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_stall  = !rdy[0];
    assign pipe.en  = rdy;
    assign pipe.v   = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_in.op           <= rat_pkg::t_op'(i_opcode);
            r_in.channel      <= i_channel;
            r_in.rel_time     <= i_rel_time;
            r_in.abs_seconds  <= i_abs_seconds;
            r_in.abs_fraction <= i_abs_fraction;
            r_in.date_format  <= i_date_format;
        end
    end

    assign ch_ok = int'(r_in.channel) < rat_pkg::CHANNELS;
    assign n_op  = ch_ok ? r_in.op : rat_pkg::OP_NOP;
    assign wr_en = r_v[0] && rdy[1] && (n_op == rat_pkg::OP_SET);

    assign wr_data.counter  = r_in.rel_time;
    assign wr_data.seconds  = r_in.abs_seconds;
    assign wr_data.fraction = r_in.abs_fraction;
    assign wr_data.format   = r_in.date_format;

    rat_ref_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (wr_en),
        .i_idx     (r_in.channel[rat_pkg::IDX_W-1:0]),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    always_comb begin
        case (n_op) inside
            rat_pkg::OP_SET:                 n_fmt = r_in.date_format;
            rat_pkg::OP_R2A, rat_pkg::OP_A2R: n_fmt = rd_data.format;
            default:                         n_fmt = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_ctx[1].op  <= n_op;
            r_ctx[1].fmt <= n_fmt;
        end
        for (int k = 2; k <= LAST - 1; k++) begin
            if (rdy[k]) begin
                r_ctx[k] <= r_ctx[k-1];
            end
        end
    end

    rat_r2a u_r2a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pipe     (pipe),
        .i_rel_time (r_in.rel_time),
        .i_ref      (rd_data),
        .o_seconds  (r2a_sec),
        .o_fraction (r2a_frac)
    );

    rat_a2r u_a2r (
        .i_clk          (i_clk),
        .i_pipe         (pipe),
        .i_abs_seconds  (r_in.abs_seconds),
        .i_abs_fraction (r_in.abs_fraction),
        .i_ref          (rd_data),
        .o_rel_time     (a2r_rel)
    );

    always_comb begin
        n_out        = '0;
        n_out.op     = r_ctx[LAST-1].op;
        n_out.format = r_ctx[LAST-1].fmt;
        case (r_ctx[LAST-1].op) inside
            rat_pkg::OP_R2A: begin
                n_out.seconds  = r2a_sec;
                n_out.fraction = r2a_frac;
            end
            rat_pkg::OP_A2R: begin
                n_out.rel_time = a2r_rel;
            end
            default: begin
                n_out.rel_time = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[LAST]) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_v[LAST];
    assign o_out_seconds  = r_out.seconds;
    assign o_out_fraction = r_out.fraction;
    assign o_out_format   = r_out.format;
    assign o_out_rel_time = r_out.rel_time;

    `RAT_CHECK(a_sec_zero, o_valid && (r_out.op != rat_pkg::OP_R2A), o_out_seconds == '0 && o_out_fraction == '0, "seconds set outside rel-to-abs")
    `RAT_CHECK(a_rel_zero, o_valid && (r_out.op != rat_pkg::OP_A2R), o_out_rel_time == '0, "counter set outside abs-to-rel")
    `RAT_CHECK_NEXT(a_set_moves, wr_en, r_v[1] && (r_ctx[1].op == rat_pkg::OP_SET), "set item lost after table write")

endmodule

`default_nettype wire
